// File: rtl/image_convolution_2d_assert.svh
// Assertion macros shared by the convolution filter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef IMAGE_CONVOLUTION_2D_ASSERT_SVH
`define IMAGE_CONVOLUTION_2D_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ICV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("icv assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ICV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("icv assertion failed");

`endif

// File: rtl/icv_pkg.sv
// Shared types and constants of the 2-D convolution filter.
// No dependencies; imported by the sequencer and the top level.
package icv_pkg;

    localparam int MAX_KERNEL_SIDE = 16;
    localparam int FRAME_SIDE      = 256;

    localparam int TAP_W   = $clog2(MAX_KERNEL_SIDE);
    localparam int KDIM_W  = TAP_W + 1;
    localparam int COORD_W = $clog2(FRAME_SIDE);
    localparam int FRAC_W  = 14;
    localparam int CHAN_W  = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = CHAN_W + 1 + COEF_W;
    localparam int ACC_W   = PROD_W + 2 * TAP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        KIND_COEF  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_REQ   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_W = 3'd0,
        CFG_KERNEL_H = 3'd1,
        CFG_ANCHOR_X = 3'd2,
        CFG_ANCHOR_Y = 3'd3,
        CFG_FRAME_W  = 3'd4,
        CFG_FRAME_H  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               pos_x;
        logic [7:0]               pos_y;
        logic [7:0]               red_in;
        logic [7:0]               green_in;
        logic [7:0]               blue_in;
        logic signed [COEF_W-1:0] coefficient;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_out;

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_TAP    = 3'd1,
        STEP_DRAIN0 = 3'd2,
        STEP_DRAIN1 = 3'd3,
        STEP_FIN    = 3'd4,
        STEP_HOLD   = 3'd5
    } t_step;

    typedef enum logic [1:0] {
        COND_ALWAYS    = 2'd0,
        COND_NO_REQ    = 2'd1,
        COND_MORE_TAPS = 2'd2,
        COND_OUT_FREE  = 2'd3
    } t_cond;

    // One control word of the sequencer program.
    typedef struct packed {
        logic  ready;
        logic  clr;
        logic  issue;
        logic  fin;
        t_cond cond;
        t_step target;
    } t_ctl;

    // Datapath status seen by the jump conditions.
    typedef struct packed {
        logic req;
        logic more_taps;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/icv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/icv_seq.sv
// Microcoded sequencer: step counter, program table and jump logic.
// Depends on icv_pkg for the control word, status and step types.
module icv_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  icv_pkg::t_stat i_stat,
    output icv_pkg::t_ctl  o_ctl
);
    import icv_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctl  ctl;
    logic  cond_true;

    // Program table
    always_comb begin
        ctl = '{ready: 1'b0, clr: 1'b0, issue: 1'b0, fin: 1'b0,
                cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (r_step)
            STEP_IDLE: begin
                ctl.ready  = 1'b1;
                ctl.clr    = 1'b1;
                ctl.cond   = COND_NO_REQ;
                ctl.target = STEP_IDLE;
            end
            STEP_TAP: begin
                ctl.issue  = 1'b1;
                ctl.cond   = COND_MORE_TAPS;
                ctl.target = STEP_TAP;
            end
            STEP_DRAIN0: begin
                ctl.cond   = COND_ALWAYS;
                ctl.target = STEP_DRAIN1;
            end
            STEP_DRAIN1: begin
                ctl.cond   = COND_ALWAYS;
                ctl.target = STEP_FIN;
            end
            STEP_FIN: begin
                ctl.fin    = 1'b1;
                ctl.cond   = COND_OUT_FREE;
                ctl.target = STEP_IDLE;
            end
            STEP_HOLD: begin
                ctl.cond   = COND_ALWAYS;
                ctl.target = STEP_FIN;
            end
            default: begin
                ctl.cond   = COND_ALWAYS;
                ctl.target = STEP_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (ctl.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NO_REQ:    cond_true = !i_stat.req;
            COND_MORE_TAPS: cond_true = i_stat.more_taps;
            COND_OUT_FREE:  cond_true = i_stat.out_free;
            default:        cond_true = 1'b1;
        endcase
    end

    // Next step: take the jump, else fall through
    always_comb begin
        if (cond_true) begin
            n_step = ctl.target;
        end else begin
            n_step = t_step'(r_step + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = ctl;

endmodule

// File: rtl/image_convolution_2d.sv
// Channel     | Handshake                    | Payload
// in          | i_in_valid / o_in_ready      | i_in_data  (icv_pkg::t_in)
// out         | o_out_valid / i_out_ready    | o_out_data (icv_pkg::t_out)
// cfg         | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// A load word leaves the filter idle and ready. A request closes the input through its taps
// (kw, kh after saturation; an empty kernel counts as one tap) and its drain and result
// steps, set by the single multiply-accumulate pass fed from one frame-memory read port.
// Reset clears control state and configuration only; frame and weight memories start
// undefined and need no clearing pass. A result waits in the output register while the
// next word is accepted; the sequencer holds only if a second result finds it still full.
//
// Top level of the 2-D convolution filter. Depends on icv_pkg, icv_ram, icv_seq and
// image_convolution_2d_assert.svh.
`include "image_convolution_2d_assert.svh"

module image_convolution_2d (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  icv_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output icv_pkg::t_out                       o_out_data,
    input  logic                                i_cfg_we,
    input  logic [icv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [icv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import icv_pkg::*;

    localparam int CRD_W   = COORD_W + 2;
    localparam int FADDR_W = 2 * COORD_W;
    localparam int WADDR_W = 2 * TAP_W;

    t_ctl  ctl;
    t_stat stat;

    // Configuration
    logic [4:0] r_kw, r_kh;
    logic [3:0] r_ax, r_ay;
    logic [8:0] r_fw, r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw <= 5'd1;
            r_kh <= 5'd1;
            r_ax <= 4'd0;
            r_ay <= 4'd0;
            r_fw <= 9'd256;
            r_fh <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL_W: r_kw <= i_cfg_data[4:0];
                CFG_KERNEL_H: r_kh <= i_cfg_data[4:0];
                CFG_ANCHOR_X: r_ax <= i_cfg_data[3:0];
                CFG_ANCHOR_Y: r_ay <= i_cfg_data[3:0];
                CFG_FRAME_W:  r_fw <= i_cfg_data;
                CFG_FRAME_H:  r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective kernel and frame limits
    logic [KDIM_W-1:0]  kw_eff, kh_eff;
    logic [COORD_W-1:0] fw_max, fh_max;
    logic               nonempty;

    always_comb begin
        kw_eff = (KDIM_W'(r_kw) > KDIM_W'(MAX_KERNEL_SIDE)) ? KDIM_W'(MAX_KERNEL_SIDE)
                                                            : KDIM_W'(r_kw);
        kh_eff = (KDIM_W'(r_kh) > KDIM_W'(MAX_KERNEL_SIDE)) ? KDIM_W'(MAX_KERNEL_SIDE)
                                                            : KDIM_W'(r_kh);
        if (r_fw == 9'd0) begin
            fw_max = '0;
        end else if (r_fw > 9'(FRAME_SIDE)) begin
            fw_max = COORD_W'(FRAME_SIDE - 1);
        end else begin
            fw_max = COORD_W'(r_fw - 9'd1);
        end
        if (r_fh == 9'd0) begin
            fh_max = '0;
        end else if (r_fh > 9'(FRAME_SIDE)) begin
            fh_max = COORD_W'(FRAME_SIDE - 1);
        end else begin
            fh_max = COORD_W'(r_fh - 9'd1);
        end
        nonempty = (r_kw != 5'd0) && (r_kh != 5'd0);
    end

    // Input word handling
    logic in_acc, req_acc, coef_we, pix_we;

    assign o_in_ready = ctl.ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign req_acc    = in_acc && (i_in_data.kind == KIND_REQ);
    assign coef_we    = in_acc && (i_in_data.kind == KIND_COEF)
                        && (i_in_data.pos_x < 8'(MAX_KERNEL_SIDE))
                        && (i_in_data.pos_y < 8'(MAX_KERNEL_SIDE));
    assign pix_we     = in_acc && (i_in_data.kind == KIND_PIXEL);

    logic [7:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_px <= i_in_data.pos_x;
            r_py <= i_in_data.pos_y;
        end
    end

    // Tap counters
    logic [TAP_W-1:0] r_col, r_row;
    logic             last_col, last_row, tap_go;

    assign last_col = (KDIM_W'(r_col) == kw_eff - KDIM_W'(1));
    assign last_row = (KDIM_W'(r_row) == kh_eff - KDIM_W'(1));
    assign tap_go   = ctl.issue && nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (tap_go) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + TAP_W'(1);
            end else begin
                r_col <= r_col + TAP_W'(1);
            end
        end
    end

    // Source coordinate of the current tap, clamped to the frame
    logic signed [CRD_W-1:0] sx_raw, sy_raw;
    logic [COORD_W-1:0]      sx, sy;

    always_comb begin
        sx_raw = $signed(CRD_W'(r_px)) - $signed(CRD_W'(r_ax)) + $signed(CRD_W'(r_col));
        sy_raw = $signed(CRD_W'(r_py)) - $signed(CRD_W'(r_ay)) + $signed(CRD_W'(r_row));
        if (sx_raw < 0) begin
            sx = '0;
        end else if (sx_raw > $signed(CRD_W'(fw_max))) begin
            sx = fw_max;
        end else begin
            sx = sx_raw[COORD_W-1:0];
        end
        if (sy_raw < 0) begin
            sy = '0;
        end else if (sy_raw > $signed(CRD_W'(fh_max))) begin
            sy = fh_max;
        end else begin
            sy = sy_raw[COORD_W-1:0];
        end
    end

    // Memories
    logic [3*CHAN_W-1:0] pix_q;
    logic [COEF_W-1:0]   coef_q;

    icv_ram #(
        .WIDTH (3 * CHAN_W),
        .DEPTH (FRAME_SIDE * FRAME_SIDE)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr ({i_in_data.pos_y[COORD_W-1:0], i_in_data.pos_x[COORD_W-1:0]}),
        .i_wdata ({i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in}),
        .i_raddr (FADDR_W'({sy, sx})),
        .o_rdata (pix_q)
    );

    icv_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_KERNEL_SIDE * MAX_KERNEL_SIDE)
    ) u_weight (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr ({i_in_data.pos_y[TAP_W-1:0], i_in_data.pos_x[TAP_W-1:0]}),
        .i_wdata (i_in_data.coefficient),
        .i_raddr (WADDR_W'({r_row, r_col})),
        .o_rdata (coef_q)
    );

    // Multiply-accumulate pipeline: read, multiply, accumulate
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic signed [ACC_W-1:0]  r_acc_r, r_acc_g, r_acc_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= tap_go;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod_r <= $signed({1'b0, pix_q[3*CHAN_W-1:2*CHAN_W]}) * $signed(coef_q);
            r_prod_g <= $signed({1'b0, pix_q[2*CHAN_W-1:CHAN_W]}) * $signed(coef_q);
            r_prod_b <= $signed({1'b0, pix_q[CHAN_W-1:0]}) * $signed(coef_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.clr) begin
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else if (r_v2) begin
            r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
            r_acc_g <= r_acc_g + ACC_W'(r_prod_g);
            r_acc_b <= r_acc_b + ACC_W'(r_prod_b);
        end
    end

    // Drop the fraction, then clip to 0..255
    function automatic logic [CHAN_W-1:0] sat_chan(input logic signed [ACC_W-1:0] acc);
        logic [CHAN_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (|acc[ACC_W-2:FRAC_W+CHAN_W]) begin
            res = '1;
        end else begin
            res = acc[FRAC_W+CHAN_W-1:FRAC_W];
        end
        return res;
    endfunction

    // Output register
    logic r_out_valid;
    t_out r_out;
    logic out_free, out_load;

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = ctl.fin && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.red_out   <= sat_chan(r_acc_r);
            r_out.green_out <= sat_chan(r_acc_g);
            r_out.blue_out  <= sat_chan(r_acc_b);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer
    assign stat = '{req: req_acc, more_taps: nonempty && !(last_col && last_row),
                    out_free: out_free};

    icv_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    `ICV_ASSERT_NOW(a_acc_not_cut, i_clk, i_rst_n, r_v2, !ctl.clr && !ctl.fin)
    `ICV_ASSERT_NOW(a_taps_wrapped, i_clk, i_rst_n, ctl.fin, r_col == '0 && r_row == '0)
    `ICV_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, req_acc, !o_in_ready)

endmodule

// File: tb/icv_filter_checker.sv
// Scoreboard for the 2-D convolution filter: keeps its own frame, weights and settings,
// works out each filtered pixel from the words it sees and checks the result words.
// Depends on icv_pkg.
module icv_filter_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  icv_pkg::t_in                     i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  icv_pkg::t_out                    i_out_data,
    input  logic                             i_cfg_we,
    input  logic [icv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [icv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import icv_pkg::*;

    logic [23:0]              frame_mem [0:FRAME_SIDE*FRAME_SIDE-1];
    logic signed [COEF_W-1:0] weights   [0:MAX_KERNEL_SIDE*MAX_KERNEL_SIDE-1];

    logic [4:0] taps_wide;
    logic [4:0] taps_high;
    logic [3:0] anchor_col;
    logic [3:0] anchor_row;
    logic [8:0] frame_cols;
    logic [8:0] frame_rows;

    t_out pixels_due [$];
    t_out want;
    int   fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Drop the fraction bits, then clip to the channel range.
    function automatic logic [7:0] clip_channel(input longint s);
        if (s < 0)
            return 8'd0;
        if ((s >>> FRAC_W) > 255)
            return 8'hFF;
        return 8'(s >>> FRAC_W);
    endfunction

    function automatic t_out filter_pixel(input logic [7:0] col, input logic [7:0] row);
        int          cols;
        int          rows;
        int          kw;
        int          kh;
        int          sx;
        int          sy;
        longint      sum_r;
        longint      sum_g;
        longint      sum_b;
        longint      w;
        logic [23:0] rgb;
        t_out        res;
        cols  = (frame_cols == 0) ? 1 : ((frame_cols > FRAME_SIDE) ? FRAME_SIDE : int'(frame_cols));
        rows  = (frame_rows == 0) ? 1 : ((frame_rows > FRAME_SIDE) ? FRAME_SIDE : int'(frame_rows));
        kw    = (taps_wide > MAX_KERNEL_SIDE) ? MAX_KERNEL_SIDE : int'(taps_wide);
        kh    = (taps_high > MAX_KERNEL_SIDE) ? MAX_KERNEL_SIDE : int'(taps_high);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int i = 0; i < kw; i++) begin
            for (int j = 0; j < kh; j++) begin
                sx = int'(col) - int'(anchor_col) + i;
                sy = int'(row) - int'(anchor_row) + j;
                sx = (sx < 0) ? 0 : ((sx > cols - 1) ? cols - 1 : sx);
                sy = (sy < 0) ? 0 : ((sy > rows - 1) ? rows - 1 : sy);
                rgb = frame_mem[sy * FRAME_SIDE + sx];
                w   = longint'(weights[j * MAX_KERNEL_SIDE + i]);
                sum_r += longint'(rgb[23:16]) * w;
                sum_g += longint'(rgb[15:8]) * w;
                sum_b += longint'(rgb[7:0]) * w;
            end
        end
        res.red_out   = clip_channel(sum_r);
        res.green_out = clip_channel(sum_g);
        res.blue_out  = clip_channel(sum_b);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            taps_wide  = 5'd1;
            taps_high  = 5'd1;
            anchor_col = 4'd0;
            anchor_row = 4'd0;
            frame_cols = 9'd256;
            frame_rows = 9'd256;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KERNEL_W: taps_wide  = i_cfg_data[4:0];
                    CFG_KERNEL_H: taps_high  = i_cfg_data[4:0];
                    CFG_ANCHOR_X: anchor_col = i_cfg_data[3:0];
                    CFG_ANCHOR_Y: anchor_row = i_cfg_data[3:0];
                    CFG_FRAME_W:  frame_cols = i_cfg_data;
                    CFG_FRAME_H:  frame_rows = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.kind)
                    KIND_COEF: begin
                        if (i_in_data.pos_x < MAX_KERNEL_SIDE && i_in_data.pos_y < MAX_KERNEL_SIDE)
                            weights[int'(i_in_data.pos_y) * MAX_KERNEL_SIDE
                                    + int'(i_in_data.pos_x)] = i_in_data.coefficient;
                    end
                    KIND_PIXEL: begin
                        frame_mem[{i_in_data.pos_y, i_in_data.pos_x}] =
                            {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
                    end
                    KIND_REQ: pixels_due.push_back(filter_pixel(i_in_data.pos_x, i_in_data.pos_y));
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pixels_due.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result word: r=%0d g=%0d b=%0d",
                                 i_out_data.red_out, i_out_data.green_out, i_out_data.blue_out);
                    fails++;
                end else begin
                    want = pixels_due.pop_front();
                    if (want.red_out !== i_out_data.red_out
                            || want.green_out !== i_out_data.green_out
                            || want.blue_out !== i_out_data.blue_out) begin
                        if (fails < 10)
                            $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     want.red_out, want.green_out, want.blue_out,
                                     i_out_data.red_out, i_out_data.green_out,
                                     i_out_data.blue_out);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= pixels_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/tb.sv
// Stimulus and verdict for the 2-D convolution filter: loads weights and pixels, sweeps
// kernel and frame settings and requests filtered pixels. Depends on icv_pkg,
// image_convolution_2d and icv_filter_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import icv_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in                   in_data   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    logic rx_idle_on = 1'b1;
    logic rx_hold    = 1'b0;
    logic hold_go    = 1'b0;
    bit   tx_idle_on = 1'b1;

    // Settings as last written, used to find the pixels and taps a request will read
    int cfg_kw = 1;
    int cfg_kh = 1;
    int cfg_ax = 0;
    int cfg_ay = 0;
    int cfg_fw = 256;
    int cfg_fh = 256;

    bit pix_done [0:FRAME_SIDE*FRAME_SIDE-1];
    bit tap_done [0:MAX_KERNEL_SIDE*MAX_KERNEL_SIDE-1];
    int words_sent = 0;

    image_convolution_2d dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    icv_filter_checker filter_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= !rx_hold && (!rx_idle_on || $urandom_range(0, 99) >= 26);
    end

    // Long receiver hold-off so that the output register fills and the input stalls
    initial begin
        do @(posedge clk); while (!hold_go);
        rx_hold <= 1'b1;
        repeat (500) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #(30_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int frame_span(input int v);
        return (v == 0) ? 1 : ((v > FRAME_SIDE) ? FRAME_SIDE : v);
    endfunction

    function automatic int kernel_span(input int v);
        return (v > MAX_KERNEL_SIDE) ? MAX_KERNEL_SIDE : v;
    endfunction

    function automatic t_in make_word(input logic [1:0] kind, input int x, input int y);
        t_in w;
        w             = t_in'({$urandom, $urandom});
        w.kind        = kind;
        w.pos_x       = 8'(x);
        w.pos_y       = 8'(y);
        return w;
    endfunction

    // Mostly weights that keep sums inside the channel range, some of any value
    function automatic logic [COEF_W-1:0] pick_weight();
        int taps;
        int v;
        taps = kernel_span(cfg_kw) * kernel_span(cfg_kh);
        if (taps == 0)
            taps = 1;
        if ($urandom_range(0, 3) == 0)
            return COEF_W'($urandom);
        v = $urandom_range(0, 40000 / taps + 200);
        return COEF_W'(v - 8000 / taps - 50);
    endfunction

    task automatic send_word(input t_in w);
        while (tx_idle_on && $urandom_range(0, 99) < 26) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (w.kind == KIND_PIXEL) begin
            pix_done[{w.pos_y, w.pos_x}] = 1'b1;
        end else if (w.kind == KIND_COEF && w.pos_x < MAX_KERNEL_SIDE
                     && w.pos_y < MAX_KERNEL_SIDE) begin
            tap_done[int'(w.pos_y) * MAX_KERNEL_SIDE + int'(w.pos_x)] = 1'b1;
        end
    endtask

    task automatic load_pixel(input int x, input int y, input logic [23:0] rgb);
        t_in w;
        w = make_word(KIND_PIXEL, x, y);
        {w.red_in, w.green_in, w.blue_in} = rgb;
        send_word(w);
    endtask

    task automatic load_tap(input int x, input int y, input logic [COEF_W-1:0] c);
        t_in w;
        w             = make_word(KIND_COEF, x, y);
        w.coefficient = c;
        send_word(w);
    endtask

    // Load any pixel or tap the window would read that has never been written, then ask.
    task automatic request_pixel(input int px, input int py);
        int kw;
        int kh;
        int fw;
        int fh;
        int sx;
        int sy;
        kw = kernel_span(cfg_kw);
        kh = kernel_span(cfg_kh);
        fw = frame_span(cfg_fw);
        fh = frame_span(cfg_fh);
        for (int j = 0; j < kh; j++) begin
            for (int i = 0; i < kw; i++) begin
                sx = px - cfg_ax + i;
                sy = py - cfg_ay + j;
                sx = (sx < 0) ? 0 : ((sx > fw - 1) ? fw - 1 : sx);
                sy = (sy < 0) ? 0 : ((sy > fh - 1) ? fh - 1 : sy);
                if (!pix_done[sy * FRAME_SIDE + sx])
                    load_pixel(sx, sy, 24'($urandom));
                if (!tap_done[j * MAX_KERNEL_SIDE + i])
                    load_tap(i, j, pick_weight());
            end
        end
        send_word(make_word(KIND_REQ, px, py));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input int v);
        cfg_we   <= 1'b1;
        cfg_idx  <= r;
        cfg_data <= CFG_DATA_W'(v);
        @(posedge clk);
    endtask

    task automatic write_config(input int kw, input int kh, input int ax, input int ay,
                                input int fw, input int fh);
        settle();
        write_reg(CFG_KERNEL_W, kw);
        write_reg(CFG_KERNEL_H, kh);
        write_reg(CFG_ANCHOR_X, ax);
        write_reg(CFG_ANCHOR_Y, ay);
        write_reg(CFG_FRAME_W, fw);
        write_reg(CFG_FRAME_H, fh);
        cfg_we <= 1'b0;
        cfg_kw = kw;
        cfg_kh = kh;
        cfg_ax = ax;
        cfg_ay = ay;
        cfg_fw = fw;
        cfg_fh = fh;
    endtask

    function automatic int pick_kernel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 4);
        if (r == 7)
            return 0;
        if (r == 8)
            return $urandom_range(5, 16);
        return $urandom_range(17, 31);
    endfunction

    function automatic int pick_frame();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 16);
        if (r == 6)
            return 0;
        if (r < 9)
            return $urandom_range(17, 256);
        return $urandom_range(257, 511);
    endfunction

    task automatic random_config();
        int kw;
        int kh;
        int ax;
        int ay;
        int fw;
        int fh;
        kw = pick_kernel();
        kh = pick_kernel();
        ax = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (kw > 16) ? 15 : ((kw > 1) ? kw - 1 : 0))
                                        : $urandom_range(0, 15);
        ay = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (kh > 16) ? 15 : ((kh > 1) ? kh - 1 : 0))
                                        : $urandom_range(0, 15);
        fw = pick_frame();
        fh = pick_frame();
        // keep the pixels a big kernel can touch few, or loading them dominates the run
        if (kernel_span(kw) * kernel_span(kh) > 16 && frame_span(fw) * frame_span(fh) > 64) begin
            fw = $urandom_range(1, 8);
            fh = $urandom_range(1, 8);
        end
        write_config(kw, kh, ax, ay, fw, fh);
    endtask

    task automatic random_word();
        int r;
        int x;
        int y;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            if ($urandom_range(0, 1)) begin
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
            end else begin
                x = $urandom_range(0, (frame_span(cfg_fw) > 254) ? 255 : frame_span(cfg_fw) + 1);
                y = $urandom_range(0, (frame_span(cfg_fh) > 254) ? 255 : frame_span(cfg_fh) + 1);
            end
            request_pixel(x, y);
        end else if (r < 65) begin
            if ($urandom_range(0, 1))
                load_pixel($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
            else
                load_pixel($urandom_range(0, frame_span(cfg_fw) - 1),
                           $urandom_range(0, frame_span(cfg_fh) - 1), 24'($urandom));
        end else if (r < 88) begin
            x = $urandom_range(0, 9);
            if (x < 8)
                load_tap($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
            else if (x == 8)
                load_tap($urandom_range(MAX_KERNEL_SIDE, 255), $urandom_range(0, 255),
                         COEF_W'($urandom));
            else
                load_tap($urandom_range(0, 255), $urandom_range(MAX_KERNEL_SIDE, 255),
                         COEF_W'($urandom));
        end else begin
            send_word(make_word(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unity weight, full-scale and empty pixels, extreme weights,
        // ignored tap loads and the unused kind.
        load_tap(0, 0, 16'sd16384);
        load_pixel(0, 0, 24'hFFFFFF);
        load_pixel(255, 255, 24'h000000);
        request_pixel(0, 0);
        request_pixel(255, 255);
        load_tap(0, 0, 16'h8000);
        request_pixel(0, 0);
        load_tap(0, 0, 16'h7FFF);
        load_pixel(255, 0, 24'h80017F);
        request_pixel(255, 0);
        load_tap(16, 0, 16'h1234);
        load_tap(0, 255, 16'h4000);
        send_word('1);
        request_pixel(255, 0);
        load_pixel(0, 255, 24'($urandom));
        load_tap(0, 0, 16'sd16384);
        request_pixel(0, 255);

        // Extreme settings: empty kernel, largest kernel and anchors, oversize and zero
        // sizes, anchor past the kernel, single-pixel frame.
        write_config(0, 7, 3, 2, 8, 8);
        repeat (3) request_pixel($urandom_range(0, 255), $urandom_range(0, 255));
        write_config(16, 16, 15, 15, 256, 256);
        request_pixel(0, 0);
        request_pixel(255, 255);
        write_config(31, 17, 0, 15, 0, 511);
        request_pixel(200, 100);
        request_pixel(255, 255);
        write_config(5, 1, 15, 0, 257, 1);
        request_pixel(3, 77);
        request_pixel(255, 0);
        write_config(1, 1, 0, 0, 1, 1);
        request_pixel(128, 128);

        // Back-pressure: receiver holds off while requests keep coming
        write_config(2, 2, 1, 1, 4, 4);
        hold_go <= 1'b1;
        repeat (30) request_pixel($urandom_range(0, 7), $urandom_range(0, 7));

        // A stretch with no idling on either side
        random_config();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (150) random_word();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;

        while (words_sent < 1800) begin
            random_config();
            repeat ($urandom_range(20, 60)) random_word();
        end

        settle();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
